>>> hw/rtl/lcdl_pkg.sv
// Package: shared constants, types and helpers for the line crossing distance log.
`default_nettype none

package lcdl_pkg;

  // Log geometry
  localparam int LOG_DEPTH = 8;
  localparam int PTR_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

  // Field widths
  localparam int DIST_W     = 32;
  localparam int LEVEL_W    = 12;
  localparam int TOL_W      = 16;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register reset values
  localparam logic [LEVEL_W-1:0] WHITE_LEVEL_RST = 12'd1000;
  localparam logic [LEVEL_W-1:0] BLACK_LEVEL_RST = 12'd2800;
  localparam logic [TOL_W-1:0]   TOLERANCE_RST   = 16'd400;

  typedef enum logic [1:0] {
    COL_NONE  = 2'd0,
    COL_BLACK = 2'd1,
    COL_WHITE = 2'd2
  } colour_t;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_POP     = 2'd1,
    REQ_CHECK   = 2'd2,
    REQ_RESTART = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_WHITE = 2'd0,
    REG_BLACK = 2'd1,
    REG_TOL   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WHITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] white_level;
    logic [LEVEL_W-1:0] black_level;
    logic [TOL_W-1:0]   distance_tolerance;
  } cfg_t;

  // Circular pointer advance: ptr + n modulo LOG_DEPTH, with n <= LOG_DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(ptr) + (CNT_W+1)'(n);
    if (sum >= (CNT_W+1)'(LOG_DEPTH)) begin
      sum = sum - (CNT_W+1)'(LOG_DEPTH);
    end
    return PTR_W'(sum);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcdl_if.sv
// Interfaces: request and result channels with valid/ready transfer.
`default_nettype none

interface lcdl_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [lcdl_pkg::LEVEL_W-1:0]     brightness;
  logic [lcdl_pkg::DIST_W-1:0]      travel_distance;
  logic signed [lcdl_pkg::DIST_W-1:0] expected_distance;

  modport source (output valid, req_type, brightness, travel_distance, expected_distance,
                  input ready);
  modport sink   (input valid, req_type, brightness, travel_distance, expected_distance,
                  output ready);
endinterface

interface lcdl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        line_found;
  logic [lcdl_pkg::DIST_W-1:0] line_distance;
  logic                        check_ok;
  logic [1:0]                  colour_state;
  logic [3:0]                  entry_count;

  modport source (output valid, line_found, line_distance, check_ok, colour_state,
                  entry_count, input ready);
  modport sink   (input valid, line_found, line_distance, check_ok, colour_state,
                  entry_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lcdl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lcdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcdl_cfg.sv
// APB configuration registers: levels and distance tolerance.
`default_nettype none

module lcdl_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lcdl_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [lcdl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [lcdl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output lcdl_pkg::cfg_t                           cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.white_level        <= lcdl_pkg::WHITE_LEVEL_RST;
      cfg.black_level        <= lcdl_pkg::BLACK_LEVEL_RST;
      cfg.distance_tolerance <= lcdl_pkg::TOLERANCE_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        lcdl_pkg::REG_WHITE: cfg.white_level        <= pwdata[lcdl_pkg::LEVEL_W-1:0];
        lcdl_pkg::REG_BLACK: cfg.black_level        <= pwdata[lcdl_pkg::LEVEL_W-1:0];
        lcdl_pkg::REG_TOL:   cfg.distance_tolerance <= pwdata[lcdl_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[3:2])
      lcdl_pkg::REG_WHITE: prdata = lcdl_pkg::APB_DATA_W'(cfg.white_level);
      lcdl_pkg::REG_BLACK: prdata = lcdl_pkg::APB_DATA_W'(cfg.black_level);
      lcdl_pkg::REG_TOL:   prdata = lcdl_pkg::APB_DATA_W'(cfg.distance_tolerance);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcdl_ctrl.sv
// Request sequencer: colour hysteresis, circular log pointers and result register.
`default_nettype none

module lcdl_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lcdl_pkg::cfg_t                cfg,
  lcdl_req_if.sink                           req,
  lcdl_rsp_if.source                         rsp,
  output logic                               mem_we,
  output logic [lcdl_pkg::PTR_W-1:0]         mem_waddr,
  output logic [lcdl_pkg::DIST_W-1:0]        mem_wdata,
  output logic [lcdl_pkg::PTR_W-1:0]         mem_raddr,
  input  wire logic [lcdl_pkg::DIST_W-1:0]   mem_rdata
);

  localparam int CNT_W  = lcdl_pkg::CNT_W;
  localparam int PTR_W  = lcdl_pkg::PTR_W;
  localparam int DIST_W = lcdl_pkg::DIST_W;
  localparam int DIFF_W = DIST_W + 2;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(lcdl_pkg::LOG_DEPTH);

  // Control state
  lcdl_pkg::state_t  state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  lcdl_pkg::colour_t colour, colour_next;
  logic              out_valid, out_valid_next;

  // Item and working registers
  lcdl_pkg::req_t               req_op, req_op_next;
  logic [lcdl_pkg::LEVEL_W-1:0] bright, bright_next;
  logic [DIST_W-1:0]            travel, travel_next;
  logic signed [DIST_W-1:0]     expected, expected_next;
  logic                         idx, idx_next;
  logic                         found, found_next;
  logic [DIST_W-1:0]            line, line_next;
  logic signed [DIFF_W-1:0]     diff, diff_next;
  logic                         ok, ok_next;

  // Result register
  logic              out_found, out_found_next;
  logic [DIST_W-1:0] out_line, out_line_next;
  logic              out_ok, out_ok_next;
  logic [1:0]        out_colour, out_colour_next;
  logic [3:0]        out_count, out_count_next;

  logic              cur_idx;
  logic              accept;
  logic              black_push;
  logic              white_push;
  logic [DIFF_W-1:0] gap;
  logic              too_far;
  logic [7:0]        count_wide;

  assign req.ready = (state == lcdl_pkg::S_IDLE);
  assign accept    = req.valid & req.ready;

  // Pending line position from count parity and colour
  assign cur_idx = (count[0] == (colour == lcdl_pkg::COL_BLACK));

  assign black_push = (colour != lcdl_pkg::COL_BLACK) && (bright > cfg.black_level);
  assign white_push = (colour != lcdl_pkg::COL_WHITE) && (bright < cfg.white_level);
  assign gap        = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign too_far    = gap > DIFF_W'(cfg.distance_tolerance);
  assign count_wide = 8'(count);

  assign rsp.valid        = out_valid;
  assign rsp.line_found   = out_found;
  assign rsp.line_distance = out_line;
  assign rsp.check_ok     = out_ok;
  assign rsp.colour_state = out_colour;
  assign rsp.entry_count  = out_count;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcdl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Log pointers, colour and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      colour    <= lcdl_pkg::COL_NONE;
      out_valid <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      colour    <= colour_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_op     <= req_op_next;
    bright     <= bright_next;
    travel     <= travel_next;
    expected   <= expected_next;
    idx        <= idx_next;
    found      <= found_next;
    line       <= line_next;
    diff       <= diff_next;
    ok         <= ok_next;
    out_found  <= out_found_next;
    out_line   <= out_line_next;
    out_ok     <= out_ok_next;
    out_colour <= out_colour_next;
    out_count  <= out_count_next;
  end

  // Next state and datapath
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    colour_next     = colour;
    out_valid_next  = out_valid & ~rsp.ready;
    req_op_next     = req_op;
    bright_next     = bright;
    travel_next     = travel;
    expected_next   = expected;
    idx_next        = idx;
    found_next      = found;
    line_next       = line;
    diff_next       = diff;
    ok_next         = ok;
    out_found_next  = out_found;
    out_line_next   = out_line;
    out_ok_next     = out_ok;
    out_colour_next = out_colour;
    out_count_next  = out_count;
    mem_we          = 1'b0;
    mem_waddr       = lcdl_pkg::wrap_add(head, count);
    mem_wdata       = travel;
    mem_raddr       = lcdl_pkg::wrap_add(head, CNT_W'(cur_idx));

    unique case (state)
      lcdl_pkg::S_IDLE: begin
        if (accept) begin
          req_op_next   = lcdl_pkg::req_t'(req.req_type);
          bright_next   = req.brightness;
          travel_next   = req.travel_distance;
          expected_next = req.expected_distance;
          idx_next      = cur_idx;
          found_next    = CNT_W'(cur_idx) < count;
          ok_next       = 1'b0;
          // Restart clears the log; the line read above still sees the old one
          if (lcdl_pkg::req_t'(req.req_type) == lcdl_pkg::REQ_RESTART) begin
            head_next   = '0;
            count_next  = '0;
            colour_next = lcdl_pkg::COL_NONE;
          end
          state_next = lcdl_pkg::S_READ;
        end
      end

      lcdl_pkg::S_READ: begin
        line_next = found ? mem_rdata : '0;
        diff_next = DIFF_W'(expected) - DIFF_W'({2'b00, mem_rdata});
        unique case (req_op)
          lcdl_pkg::REQ_POP: begin
            if (found) begin
              head_next  = lcdl_pkg::wrap_add(head, CNT_W'(idx) + CNT_W'(1));
              count_next = count - (CNT_W'(idx) + CNT_W'(1));
            end
            state_next = lcdl_pkg::S_DONE;
          end
          lcdl_pkg::REQ_CHECK: begin
            state_next = lcdl_pkg::S_CHECK;
          end
          lcdl_pkg::REQ_SAMPLE, lcdl_pkg::REQ_RESTART: begin
            // Black transition: push, overwriting the oldest entry when full
            if (black_push) begin
              mem_we      = 1'b1;
              colour_next = lcdl_pkg::COL_BLACK;
              if (count == FULL) begin
                head_next = lcdl_pkg::wrap_add(head, CNT_W'(1));
              end else begin
                count_next = count + CNT_W'(1);
              end
            end
            state_next = lcdl_pkg::S_WHITE;
          end
        endcase
      end

      lcdl_pkg::S_CHECK: begin
        if (found) begin
          if (too_far) begin
            head_next  = lcdl_pkg::wrap_add(head, CNT_W'(idx) + CNT_W'(1));
            count_next = count - (CNT_W'(idx) + CNT_W'(1));
          end else begin
            ok_next = 1'b1;
          end
        end
        state_next = lcdl_pkg::S_DONE;
      end

      lcdl_pkg::S_WHITE: begin
        if (white_push) begin
          colour_next = lcdl_pkg::COL_WHITE;
          if (travel != '0) begin
            mem_we = 1'b1;
            if (count == FULL) begin
              head_next = lcdl_pkg::wrap_add(head, CNT_W'(1));
            end else begin
              count_next = count + CNT_W'(1);
            end
          end else if (count == FULL) begin
            // Zero-distance white on a full log: oldest dropped, push taken back
            head_next  = lcdl_pkg::wrap_add(head, CNT_W'(1));
            count_next = count - CNT_W'(1);
          end
        end
        state_next = lcdl_pkg::S_DONE;
      end

      lcdl_pkg::S_DONE: begin
        // Load the result once the output register is free
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_found_next  = found;
          out_line_next   = line;
          out_ok_next     = ok;
          out_colour_next = colour;
          out_count_next  = count_wide[3:0];
          state_next      = lcdl_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = lcdl_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("log count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    32'(head) < lcdl_pkg::LOG_DEPTH)
    else $error("head pointer out of range");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == lcdl_pkg::S_READ || state == lcdl_pkg::S_WHITE))
    else $error("log write outside a push step");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == lcdl_pkg::S_READ)
    else $error("accepted request did not start a read");

  a_ok_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_ok && !out_found))
    else $error("check passed without a pending line");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/line_crossing_distance_log_unit.sv
// Top level: line crossing distance log with APB configuration.
`default_nettype none

// Classifies brightness samples as black or white with two thresholds and logs the
// travel distance of each colour transition in a circular log of LOG_DEPTH entries,
// held in a one-port-write, one-port-read RAM. Every request gives one result: the
// white line pending before the request acted, its distance, the check verdict, and
// the colour and entry count after it. After the transfer a request goes through the
// registered RAM read of the pending entry, then the black push and the white push
// for a sample or restart, or the check compare for a check (a pop skips straight on),
// and last the load of the result register, which waits while that register is full.
// Two pushes per sample share the single RAM write port. The log needs no clearing
// after reset or restart: only entries below the fill count are ever read. A finished
// result may wait in the output register while the next request is taken in.
module line_crossing_distance_log_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lcdl_req_if.sink                             req,
  lcdl_rsp_if.source                           rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lcdl_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lcdl_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lcdl_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  lcdl_pkg::cfg_t                cfg;
  logic                          mem_we;
  logic [lcdl_pkg::PTR_W-1:0]    mem_waddr;
  logic [lcdl_pkg::DIST_W-1:0]   mem_wdata;
  logic [lcdl_pkg::PTR_W-1:0]    mem_raddr;
  logic [lcdl_pkg::DIST_W-1:0]   mem_rdata;

  // Configuration registers
  lcdl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Request sequencer
  lcdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Transition log storage
  lcdl_ram #(
    .WIDTH (lcdl_pkg::DIST_W),
    .DEPTH (lcdl_pkg::LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
